// ----- sv/qcf_pkg.sv -----
// ============================================================================
// qcf_pkg
// Shared types, constants and helper functions for the quadratic curve
// flattener: point and piece formats, register indexes, state encoding.
// ============================================================================
`default_nettype none

package qcf_pkg;

   // Default parameter values for the top level.
   localparam int DEF_MAX_DEPTH = 6;
   localparam int DEF_FRAC_BITS = 8;

   // Fixed field widths.
   localparam int IN_W    = 16;
   localparam int COORD_W = 24;
   localparam int FLAT_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLATNESS = 3'd4;

   // Coordinate slots handled by the transform unit, in processing order.
   localparam int NUM_COORDS = 6;
   localparam int CIDX_W     = 3;
   localparam logic [CIDX_W-1:0] CI_BEG_X  = 3'd0;
   localparam logic [CIDX_W-1:0] CI_BEG_Y  = 3'd1;
   localparam logic [CIDX_W-1:0] CI_CTRL_X = 3'd2;
   localparam logic [CIDX_W-1:0] CI_CTRL_Y = 3'd3;
   localparam logic [CIDX_W-1:0] CI_END_X  = 3'd4;
   localparam logic [CIDX_W-1:0] CI_END_Y  = 3'd5;

   // Saturation limits of a transformed coordinate.
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef logic signed [COORD_W-1:0] coord_type;

   // A point, x in the upper half.
   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // One curve piece: start, control and end point.
   typedef struct packed {
      point_type b;
      point_type c;
      point_type e;
   } piece_type;

   // Input word as latched at acceptance.
   typedef struct packed {
      logic                 line;
      logic signed [IN_W-1:0] beg_x;
      logic signed [IN_W-1:0] beg_y;
      logic signed [IN_W-1:0] ctrl_x;
      logic signed [IN_W-1:0] ctrl_y;
      logic signed [IN_W-1:0] end_x;
      logic signed [IN_W-1:0] end_y;
   } req_type;

   // One emitted segment.
   typedef struct packed {
      point_type b;
      point_type e;
      logic      last;
   } seg_type;

   // Status of the subdivision engine toward the top level.
   typedef struct packed {
      logic idle;
      logic stack_empty;
   } walk_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XFORM,
      ST_WORK,
      ST_POP
   } state_type;

   // Midpoint of two coordinates, rounded toward minus infinity.
   function automatic coord_type half_floor(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

   function automatic point_type mid_point(input point_type a, input point_type b);
      point_type m;
      m.x = half_floor(a.x, b.x);
      m.y = half_floor(a.y, b.y);
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- sv/quadratic_curve_flattener_unit.sv -----
// ============================================================================
// quadratic_curve_flattener_unit
// Scales and offsets a line or quadratic curve and flattens the curve into
// line segments by depth-first midpoint subdivision.
// ============================================================================
// Usage:
//   req_*  : one word per line or curve; tuser = 1 for a straight line.
//   rsp_*  : one word per segment, in drawing order; tlast marks the last
//            segment of an item.
//   csr_*  : register writes, only while the block is idle.
// Operation: the transform unit shares one multiplier over the six
// coordinates of an item. The engine then either splits the current piece
// or emits it and, unless the item is finished, reads the next piece from
// the stack memory in ST_POP; a curve yields up to 64 segments at the
// default depth, a line yields one.
// One item is in work at a time; req_tready returns high once the last
// segment sits in the output register, so the next word can be taken while
// that segment still waits on rsp_tready.
// A stalled receiver holds the engine at its next emit; nothing is dropped.
// Reset clears the sequencer, the output valid and loads register defaults;
// the stack memory needs no clearing.
// ============================================================================
`default_nettype none

module quadratic_curve_flattener_unit
   import qcf_pkg::*;
#(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: beg_x, beg_y, ctrl_x, ctrl_y, end_x, end_y
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [95:0]           req_tdata,
   // tuser: operation
   input  wire logic                  req_tuser,
   // tdata: seg_beg_x, seg_beg_y, seg_end_x, seg_end_y
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [95:0]                rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LVL_W = $clog2(MAX_DEPTH + 1);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);

   logic signed [IN_W-1:0]    scale_x_ff, scale_y_ff;
   logic signed [COORD_W-1:0] move_x_ff, move_y_ff;
   logic [FLAT_W-1:0]         flatness_ff;
   req_type                   req_ff;
   logic                      req_fire;
   logic                      xf_done;
   piece_type                 xf_pts;
   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   piece_type                 wr_piece, rd_piece;
   logic [LVL_W-1:0]          wr_level, rd_level;
   seg_type                   rsp_seg;
   walk_status_type           status;

   assign req_tready = status.idle;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= IN_W'(1 << FRAC_BITS);
         scale_y_ff  <= IN_W'(1 << FRAC_BITS);
         move_x_ff   <= '0;
         move_y_ff   <= '0;
         flatness_ff <= FLAT_W'((1 << FRAC_BITS) >> 1);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SCALE_X:  scale_x_ff  <= csr_wdata[IN_W-1:0];
            REG_SCALE_Y:  scale_y_ff  <= csr_wdata[IN_W-1:0];
            REG_MOVE_X:   move_x_ff   <= csr_wdata[COORD_W-1:0];
            REG_MOVE_Y:   move_y_ff   <= csr_wdata[COORD_W-1:0];
            REG_FLATNESS: flatness_ff <= csr_wdata[FLAT_W-1:0];
            default:      ;
         endcase
      end
   end

   // Input word latch.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.line   <= req_tuser;
         req_ff.beg_x  <= req_tdata[15:0];
         req_ff.beg_y  <= req_tdata[31:16];
         req_ff.ctrl_x <= req_tdata[47:32];
         req_ff.ctrl_y <= req_tdata[63:48];
         req_ff.end_x  <= req_tdata[79:64];
         req_ff.end_y  <= req_tdata[95:80];
      end
   end

   qcf_xform u_xform (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .req     (req_ff),
      .scale_x (scale_x_ff),
      .scale_y (scale_y_ff),
      .move_x  (move_x_ff),
      .move_y  (move_y_ff),
      .done    (xf_done),
      .pts     (xf_pts)
   );

   qcf_stack #(
      .DEPTH (MAX_DEPTH),
      .AW    (AW),
      .LVL_W (LVL_W)
   ) u_stack (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_piece (wr_piece),
      .wr_level (wr_level),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_piece (rd_piece),
      .rd_level (rd_level)
   );

   qcf_walk #(
      .MAX_DEPTH (MAX_DEPTH),
      .AW        (AW),
      .LVL_W     (LVL_W),
      .CNT_W     (CNT_W)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .line_op   (req_tuser),
      .xf_done   (xf_done),
      .xf_pts    (xf_pts),
      .flatness  (flatness_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_piece  (wr_piece),
      .wr_level  (wr_level),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_piece  (rd_piece),
      .rd_level  (rd_level),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_seg   (rsp_seg),
      .status    (status)
   );

   assign rsp_tdata = {rsp_seg.e.y, rsp_seg.e.x, rsp_seg.b.y, rsp_seg.b.x};
   assign rsp_tlast = rsp_seg.last;

   // The block is ready for a new word right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // An accepted word keeps the input closed for at least the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input accepted a second word while busy");

   // Every item leaves the deferred-piece stack empty.
   a_stack_empty_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> status.stack_empty)
      else $error("stack not empty while idle");

endmodule

`default_nettype wire

// ----- sv/qcf_xform.sv -----
// ============================================================================
// qcf_xform
// Scale and offset unit: one shared 16x16 multiplier handles the six input
// coordinates in turn, followed by an offset add and 24-bit saturation.
// ============================================================================
`default_nettype none

module qcf_xform
   import qcf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire req_type                   req,
   input  wire logic signed [IN_W-1:0]    scale_x,
   input  wire logic signed [IN_W-1:0]    scale_y,
   input  wire logic signed [COORD_W-1:0] move_x,
   input  wire logic signed [COORD_W-1:0] move_y,
   output logic                           done,
   output piece_type                      pts
);

   logic                        run_ff, run_in;
   logic [CIDX_W-1:0]           cnt_ff, cnt_in;
   logic                        mvalid_ff;
   logic [CIDX_W-1:0]           widx_ff;
   logic signed [2*IN_W-1:0]    mul_ff, mul_in;
   logic signed [COORD_W-1:0]   mv_ff, mv_in;
   logic                        done_ff;
   coord_type                   res_ff [NUM_COORDS];
   logic signed [IN_W-1:0]      coord_sel;
   logic signed [IN_W-1:0]      scale_sel;
   logic signed [2*IN_W:0]      sum;
   coord_type                   sat;

   // Pick the coordinate of this step; even slots are x, odd slots are y.
   always_comb begin
      case (cnt_ff)
         CI_BEG_X:  coord_sel = req.beg_x;
         CI_BEG_Y:  coord_sel = req.beg_y;
         CI_CTRL_X: coord_sel = req.ctrl_x;
         CI_CTRL_Y: coord_sel = req.ctrl_y;
         CI_END_X:  coord_sel = req.end_x;
         CI_END_Y:  coord_sel = req.end_y;
         default:   coord_sel = '0;
      endcase
      scale_sel = cnt_ff[0] ? scale_y : scale_x;
      mul_in    = coord_sel * scale_sel;
      mv_in     = cnt_ff[0] ? move_y : move_x;
   end

   // Step counter: six multiply steps after each start.
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CI_END_Y) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         cnt_ff    <= '0;
         mvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         cnt_ff    <= cnt_in;
         mvalid_ff <= run_ff;
         done_ff   <= mvalid_ff && (widx_ff == CI_END_Y);
      end
   end

   // Product register stage.
   always_ff @(posedge clock) begin
      mul_ff  <= mul_in;
      mv_ff   <= mv_in;
      widx_ff <= cnt_ff;
   end

   // Offset add and clamp to the signed 24-bit range.
   always_comb begin
      sum = {mul_ff[2*IN_W-1], mul_ff}
          + {{(2*IN_W+1-COORD_W){mv_ff[COORD_W-1]}}, mv_ff};
      if (sum > $signed({{(2*IN_W+1-COORD_W){1'b0}}, COORD_MAX})) begin
         sat = COORD_MAX;
      end else if (sum < $signed({{(2*IN_W+1-COORD_W){1'b1}}, COORD_MIN})) begin
         sat = COORD_MIN;
      end else begin
         sat = sum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mvalid_ff) begin
         res_ff[widx_ff] <= sat;
      end
   end

   assign done    = done_ff;
   assign pts.b.x = res_ff[CI_BEG_X];
   assign pts.b.y = res_ff[CI_BEG_Y];
   assign pts.c.x = res_ff[CI_CTRL_X];
   assign pts.c.y = res_ff[CI_CTRL_Y];
   assign pts.e.x = res_ff[CI_END_X];
   assign pts.e.y = res_ff[CI_END_Y];

endmodule

`default_nettype wire

// ----- sv/qcf_stack.sv -----
// ============================================================================
// qcf_stack
// Deferred-piece memory: one write port and one read port with a registered
// read, holding the right halves awaiting subdivision and their levels.
// ============================================================================
`default_nettype none

module qcf_stack
   import qcf_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_DEPTH,
   parameter int AW    = 3,
   parameter int LVL_W = 3
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire piece_type        wr_piece,
   input  wire logic [LVL_W-1:0] wr_level,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output piece_type             rd_piece,
   output logic [LVL_W-1:0]      rd_level
);

   piece_type        piece_mem [DEPTH];
   logic [LVL_W-1:0] level_mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         piece_mem[wr_addr] <= wr_piece;
         level_mem[wr_addr] <= wr_level;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_piece <= piece_mem[rd_addr];
         rd_level <= level_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/qcf_walk.sv -----
// ============================================================================
// qcf_walk
// Subdivision engine: runs the depth-first midpoint split of one curve,
// pushing right halves to the stack memory and loading the output register
// with each piece that is flat, a line, or at the depth or stack limit.
// ============================================================================
`default_nettype none

module qcf_walk
   import qcf_pkg::*;
#(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int AW        = 3,
   parameter int LVL_W     = 3,
   parameter int CNT_W     = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              line_op,
   input  wire logic              xf_done,
   input  wire piece_type         xf_pts,
   input  wire logic [FLAT_W-1:0] flatness,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output piece_type              wr_piece,
   output logic [LVL_W-1:0]       wr_level,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  wire piece_type         rd_piece,
   input  wire logic [LVL_W-1:0]  rd_level,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output seg_type                rsp_seg,
   output walk_status_type        status
);

   state_type              state_ff, state_in;
   point_type              b_ff, c_ff, e_ff;
   logic [LVL_W-1:0]       level_ff;
   logic                   line_ff;
   logic [CNT_W-1:0]       sp_ff;
   logic [MAX_DEPTH-1:0]   nseg_ff;
   logic                   out_valid_ff;
   seg_type                out_seg_ff;

   point_type              chord_mid, c0, c1, pv;
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]       adx, ady;
   logic [COORD_W+1:0]     man_dist;
   logic                   flat;
   logic                   emit_now;
   logic                   out_free;
   logic                   finish;
   logic                   do_emit, do_split, do_load_xf, do_load_pop;

   // Flatness test: Manhattan distance from control point to chord midpoint.
   always_comb begin
      chord_mid = mid_point(b_ff, e_ff);
      dx   = {c_ff.x[COORD_W-1], c_ff.x} - {chord_mid.x[COORD_W-1], chord_mid.x};
      dy   = {c_ff.y[COORD_W-1], c_ff.y} - {chord_mid.y[COORD_W-1], chord_mid.y};
      adx  = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
      ady  = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
      man_dist = {1'b0, adx} + {1'b0, ady};
      flat = man_dist <= {{(COORD_W+2-FLAT_W){1'b0}}, flatness};
   end

   // Split of the current piece into left and right halves.
   always_comb begin
      c0 = mid_point(b_ff, c_ff);
      c1 = mid_point(c_ff, e_ff);
      pv = mid_point(c0, c1);
   end

   assign emit_now = line_ff
                  || (level_ff >= LVL_W'(MAX_DEPTH))
                  || (sp_ff >= CNT_W'(MAX_DEPTH))
                  || flat;
   assign out_free = !out_valid_ff || rsp_ready;
   assign finish   = (sp_ff == '0) || (&nseg_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_XFORM;
         end
         ST_XFORM: begin
            if (xf_done) state_in = ST_WORK;
         end
         ST_WORK: begin
            if (emit_now && out_free) begin
               state_in = finish ? ST_IDLE : ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_WORK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      do_emit     = 1'b0;
      do_split    = 1'b0;
      do_load_xf  = 1'b0;
      do_load_pop = 1'b0;
      case (state_ff)
         ST_IDLE:  ;
         ST_XFORM: do_load_xf = xf_done;
         ST_WORK: begin
            do_emit  = emit_now && out_free;
            do_split = !emit_now;
         end
         ST_POP:   do_load_pop = 1'b1;
         default:  ;
      endcase
      wr_en = do_split;
      rd_en = do_emit && !finish;
   end

   // Stack ports: push at the count, pop from one below it.
   assign wr_addr    = sp_ff[AW-1:0];
   assign wr_piece.b = pv;
   assign wr_piece.c = c1;
   assign wr_piece.e = e_ff;
   assign wr_level   = level_ff + 1'b1;
   assign rd_addr    = AW'(sp_ff - 1'b1);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_load_xf) begin
            sp_ff <= '0;
         end else if (do_split) begin
            sp_ff <= sp_ff + 1'b1;
         end else if (rd_en) begin
            sp_ff <= sp_ff - 1'b1;
         end
         if (do_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Current piece, level and segment count.
   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         line_ff <= line_op;
      end
      if (do_load_xf) begin
         b_ff     <= xf_pts.b;
         c_ff     <= xf_pts.c;
         e_ff     <= xf_pts.e;
         level_ff <= '0;
         nseg_ff  <= '0;
      end else if (do_load_pop) begin
         b_ff     <= rd_piece.b;
         c_ff     <= rd_piece.c;
         e_ff     <= rd_piece.e;
         level_ff <= rd_level;
      end else if (do_split) begin
         c_ff     <= c0;
         e_ff     <= pv;
         level_ff <= level_ff + 1'b1;
      end
      if (do_emit) begin
         nseg_ff         <= nseg_ff + 1'b1;
         out_seg_ff.b    <= b_ff;
         out_seg_ff.e    <= e_ff;
         out_seg_ff.last <= (sp_ff == '0);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_seg            = out_seg_ff;
   assign status.idle        = (state_ff == ST_IDLE);
   assign status.stack_empty = (sp_ff == '0);

endmodule

`default_nettype wire
